[src/gnms_pkg.sv]
// ----------------------------------------------------------------------------
// gnms_pkg
// Types and constants shared by the non-maximum suppression block.
// ----------------------------------------------------------------------------
package gnms_pkg;

    localparam int GRAD_W   = 11;   // signed Sobel gradient
    localparam int ABS_W    = 11;   // |gradient|, up to 1024
    localparam int SQ_W     = 21;   // square of |gradient|
    localparam int MAG2_W   = 22;   // squared magnitude
    localparam int SQRT_IN  = 30;   // squared magnitude scaled by 256
    localparam int ROOT_W   = 15;   // Q11.4 magnitude
    localparam int MAG_W    = 15;
    localparam int COL_O_W  = 10;
    localparam int ROW_W    = 12;
    localparam int HGT_W    = 13;
    localparam int FW_W     = 11;
    localparam int CFG_W    = 13;
    localparam int MAX_HEIGHT = 4096;

    // direction sectors
    localparam logic [1:0] SEC_HORZ = 2'd0;
    localparam logic [1:0] SEC_DIAG = 2'd1;   // same signs
    localparam logic [1:0] SEC_VERT = 2'd2;
    localparam logic [1:0] SEC_ANTI = 2'd3;   // opposite signs

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [MAG2_W-1:0] mag2;
        logic [1:0]        sector;
    } t_grad_res;

endpackage

[src/gnms_grad.sv]
// ----------------------------------------------------------------------------
// gnms_grad
// Squared magnitude and direction sector of one gradient pair; products are
// registered on load, the sum and sector compares follow from the registers.
// ----------------------------------------------------------------------------
module gnms_grad (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic signed [gnms_pkg::GRAD_W-1:0] i_gx,
    input  logic signed [gnms_pkg::GRAD_W-1:0] i_gy,
    output gnms_pkg::t_grad_res           o_res
);
    import gnms_pkg::*;

    logic [ABS_W-1:0]   a, b, d;
    logic [ABS_W:0]     s;
    logic               ge, same;
    logic [SQ_W-1:0]    r_a2, r_b2, r_d2;
    logic [SQ_W+1:0]    r_s2;
    logic               r_ge, r_same;
    logic [MAG2_W-1:0]  twoa2;
    logic               horz, vert;

    always_comb begin
        a    = i_gx[GRAD_W-1] ? ABS_W'(~i_gx + 1'b1) : ABS_W'(i_gx);
        b    = i_gy[GRAD_W-1] ? ABS_W'(~i_gy + 1'b1) : ABS_W'(i_gy);
        s    = {1'b0, a} + {1'b0, b};
        ge   = (b >= a);
        d    = b - a;
        same = (i_gx[GRAD_W-1] == i_gy[GRAD_W-1]);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a2   <= SQ_W'(a * a);
            r_b2   <= SQ_W'(b * b);
            r_d2   <= SQ_W'(d * d);
            r_s2   <= (SQ_W+2)'(s * s);
            r_ge   <= ge;
            r_same <= same;
        end
    end

    always_comb begin
        twoa2       = {r_a2, 1'b0};
        horz        = (r_s2 < {1'b0, twoa2});
        vert        = r_ge && ({1'b0, r_d2} >= twoa2);
        o_res.mag2  = {1'b0, r_a2} + {1'b0, r_b2};
        if (horz)
            o_res.sector = SEC_HORZ;
        else if (vert)
            o_res.sector = SEC_VERT;
        else
            o_res.sector = r_same ? SEC_DIAG : SEC_ANTI;
    end

endmodule

[src/gnms_sqrt.sv]
// ----------------------------------------------------------------------------
// gnms_sqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module gnms_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [gnms_pkg::SQRT_IN-1:0]  i_value,
    output logic                          o_done,
    output logic [gnms_pkg::ROOT_W-1:0]   o_root
);
    import gnms_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [REM_W-1:0]   r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [SQRT_IN-1:0] r_val;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy, r_done;
    logic [REM_W+1:0]   rem_sh, trial;

    always_comb begin
        rem_sh = {r_rem, r_val[SQRT_IN-1 -: 2]};
        trial  = {2'b00, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_root <= '0;
            r_val  <= i_value;
        end else if (r_busy) begin
            r_val <= {r_val[SQRT_IN-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= REM_W'(rem_sh - trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= REM_W'(rem_sh);
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[src/gradient_nonmax_suppression.sv]
// ----------------------------------------------------------------------------
// gradient_nonmax_suppression
// Non-maximum suppression of Sobel gradients in raster order: line memories
// of squared magnitude and sector, a 3x3 window, neighbour compare and a
// serial square root giving the surviving magnitude in Q11.4.
// ----------------------------------------------------------------------------
//  channel | handshake                    | payload
//  --------+------------------------------+---------------------------------
//  input   | i_in_valid  / o_in_ready     | i_grad_x, i_grad_y
//  output  | o_out_valid / i_out_ready    | o_edge_magnitude, o_centre_column,
//          |                              | o_centre_row, o_frame_last
//  config  | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// An input word that yields no result (border centre) passes through the
// idle and update states; a suppressed centre adds the compare and output
// states; a kept centre also waits in the root state, the square root unit
// giving one result bit per cycle. Reset is synchronous, active low,
// and clears counters, window and control; line memories are not cleared.
// The output register holds a result while the next word is taken; a new
// result waits in the final state until the output register frees.
// ----------------------------------------------------------------------------
module gradient_nonmax_suppression #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [gnms_pkg::GRAD_W-1:0] i_grad_x,
    input  logic signed [gnms_pkg::GRAD_W-1:0] i_grad_y,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [gnms_pkg::MAG_W-1:0]         o_edge_magnitude,
    output logic [gnms_pkg::COL_O_W-1:0]       o_centre_column,
    output logic [gnms_pkg::ROW_W-1:0]         o_centre_row,
    output logic                               o_frame_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_index,
    input  logic [gnms_pkg::CFG_W-1:0]         i_cfg_data
);
    import gnms_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);   // column counter
    localparam int WW = CW + 1;              // effective width
    localparam int AW = CW + 1;              // magnitude memory address

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UPD  = 5'b00010,
        S_CMP  = 5'b00100,
        S_SQRT = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state;

    // configuration
    logic [FW_W-1:0]  r_frame_width;
    logic [HGT_W-1:0] r_frame_height;
    logic [WW-1:0]    eff_w;
    logic [HGT_W-1:0] eff_h;

    // position
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic             col_wrap, row_wrap, emit;

    // line memories
    logic [MAG2_W-1:0] mag_mem [2*MAX_WIDTH];
    logic [1:0]        sec_mem [MAX_WIDTH];
    logic [MAG2_W-1:0] r_rd_cur, r_rd_prev;
    logic [1:0]        r_rd_sec;
    logic [AW-1:0]     addr_cur, addr_prev;
    logic              in_acc, upd;

    // window and sector delay
    logic [MAG2_W-1:0] r_win [3][3];
    logic [1:0]        r_sec_hold, r_csec;
    logic [MAG2_W-1:0] n1, n2, centre;
    logic              keep;

    // result
    logic [COL_O_W-1:0] r_col_o;
    logic [ROW_W-1:0]   r_row_o;
    logic               r_last_o;
    logic [MAG_W-1:0]   r_res;
    logic               r_out_valid;
    logic [MAG_W-1:0]   r_mag_q;
    logic [COL_O_W-1:0] r_col_q;
    logic [ROW_W-1:0]   r_row_q;
    logic               r_last_q;
    logic               out_load;

    t_grad_res         grad;
    logic              sq_start, sq_done;
    logic [ROOT_W-1:0] sq_root;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign upd         = (r_state == S_UPD);

    // clamp registers to their legal ranges
    always_comb begin
        if (r_frame_width < FW_W'(3))
            eff_w = WW'(3);
        else if (32'(r_frame_width) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(r_frame_width);
        if (r_frame_height < HGT_W'(3))
            eff_h = HGT_W'(3);
        else if (32'(r_frame_height) > MAX_HEIGHT)
            eff_h = HGT_W'(MAX_HEIGHT);
        else
            eff_h = r_frame_height;
    end

    always_comb begin
        col_wrap  = ({1'b0, r_col} + 1'b1) >= eff_w;
        row_wrap  = ({1'b0, r_row} + 1'b1) >= eff_h;
        emit      = (r_row >= ROW_W'(2)) && (r_col >= CW'(2));
        addr_cur  = {r_row[0], r_col};
        addr_prev = {~r_row[0], r_col};
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_W'(640);
            r_frame_height <= HGT_W'(480);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                REG_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gnms_grad u_grad (
        .i_clk  (i_clk),
        .i_load (in_acc),
        .i_gx   (i_grad_x),
        .i_gy   (i_grad_y),
        .o_res  (grad)
    );

    // magnitude lines: two rows, read old values on accept, write back next
    always_ff @(posedge i_clk) begin
        if (upd)
            mag_mem[addr_cur] <= grad.mag2;
        if (in_acc) begin
            r_rd_cur  <= mag_mem[addr_cur];
            r_rd_prev <= mag_mem[addr_prev];
        end
    end

    // sector line: one row
    always_ff @(posedge i_clk) begin
        if (upd)
            sec_mem[r_col] <= grad.sector;
        if (in_acc)
            r_rd_sec <= sec_mem[r_col];
    end

    // neighbour choice along the centre's sector
    always_comb begin
        centre = r_win[1][1];
        case (r_csec)
            SEC_HORZ: begin n1 = r_win[1][0]; n2 = r_win[1][2]; end
            SEC_DIAG: begin n1 = r_win[0][2]; n2 = r_win[2][0]; end
            SEC_VERT: begin n1 = r_win[0][1]; n2 = r_win[2][1]; end
            default:  begin n1 = r_win[0][0]; n2 = r_win[2][2]; end
        endcase
        keep     = (centre >= n1) && (centre >= n2);
        sq_start = (r_state == S_CMP) && keep;
    end

    gnms_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value ({centre, 8'h00}),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // sequencer, counters, window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_col      <= '0;
            r_row      <= '0;
            r_sec_hold <= SEC_HORZ;
            r_csec     <= SEC_HORZ;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    r_win[i][j] <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc)
                        r_state <= S_UPD;
                end
                S_UPD: begin
                    for (int i = 0; i < 3; i++) begin
                        r_win[i][0] <= r_win[i][1];
                        r_win[i][1] <= r_win[i][2];
                    end
                    r_win[0][2] <= r_rd_cur;
                    r_win[1][2] <= r_rd_prev;
                    r_win[2][2] <= grad.mag2;
                    r_csec      <= r_sec_hold;
                    r_sec_hold  <= r_rd_sec;
                    if (col_wrap) begin
                        r_col <= '0;
                        r_row <= row_wrap ? '0 : r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                    r_state <= emit ? S_CMP : S_IDLE;
                end
                S_CMP: begin
                    r_state <= keep ? S_SQRT : S_OUT;
                end
                S_SQRT: begin
                    if (sq_done)
                        r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result fields held until the output register frees
    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_col_o  <= COL_O_W'(r_col - 1'b1);
            r_row_o  <= r_row - 1'b1;
            r_last_o <= col_wrap && row_wrap;
        end
        if (r_state == S_CMP && !keep)
            r_res <= '0;
        else if (r_state == S_SQRT && sq_done)
            r_res <= sq_root;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_mag_q  <= r_res;
            r_col_q  <= r_col_o;
            r_row_q  <= r_row_o;
            r_last_q <= r_last_o;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_edge_magnitude = r_mag_q;
    assign o_centre_column  = r_col_q;
    assign o_centre_row     = r_row_q;
    assign o_frame_last     = r_last_q;

endmodule
